// File: hw/rtl/pph_pkg.sv
package pph_pkg;

    typedef enum logic [2:0]
    {
        MODE_SIN     = 3'd0,
        MODE_SOUT    = 3'd1,
        MODE_STIN    = 3'd2,
        MODE_STOUT   = 3'd3,
        MODE_BIDIR   = 3'd4,
        MODE_BITPROG = 3'd5
    } mode_t;

    typedef enum logic [1:0]
    {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_DONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        EV_NONE     = 2'd0,
        EV_SIMPLE   = 2'd1,
        EV_STROBED  = 2'd2
    } event_t;

    localparam logic [1:0] PORT_A = 2'd0;
    localparam logic [1:0] PORT_B = 2'd1;
    localparam logic [1:0] PORT_C = 2'd2;

    localparam logic [2:0] REG_MODE_A   = 3'd0;
    localparam logic [2:0] REG_MODE_B   = 3'd1;
    localparam logic [2:0] REG_MODE_C   = 3'd2;
    localparam logic [2:0] REG_DIR_A    = 3'd3;
    localparam logic [2:0] REG_DIR_B    = 3'd4;
    localparam logic [2:0] REG_DIR_C    = 3'd5;
    localparam logic [2:0] REG_IMPL_C   = 3'd6;
    localparam logic [2:0] REG_IRQ_EN   = 3'd7;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed
    {
        logic [7:0] rd;
        logic [7:0] out_latch;
        event_t     ev;
        logic       taken;
        logic       ibf;
        logic       obe;
        logic       irq;
    } port_res_t;

    function automatic logic [7:0] merge_io(input logic [7:0] inv, input logic [7:0] outv,
                                            input logic [7:0] dir);
        merge_io = (inv & ~dir) | (outv & dir);
    endfunction

endpackage

// File: hw/rtl/pph_port.sv
module pph_port
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              hit,
    input  pph_pkg::cmd_t     cmd,
    input  logic [7:0]        data,
    input  logic [7:0]        pins,
    input  logic [2:0]        mode,
    input  logic [7:0]        dir,
    input  logic              irq_en,
    output pph_pkg::port_res_t res
);
    import pph_pkg::*;

    logic [7:0] in_latch_reg;
    logic [7:0] in_latch_next;
    logic [7:0] out_latch_reg;
    logic [7:0] out_latch_next;
    logic       ibf_reg;
    logic       ibf_next;
    logic       obe_reg;
    logic       obe_next;
    logic       strobed_in;
    logic       strobed_out;

    assign strobed_in  = (mode == MODE_STIN)  || (mode == MODE_BIDIR);
    assign strobed_out = (mode == MODE_STOUT) || (mode == MODE_BIDIR);

    always_comb
    begin
        in_latch_next  = in_latch_reg;
        out_latch_next = out_latch_reg;
        ibf_next       = ibf_reg;
        obe_next       = obe_reg;
        res.rd         = BYTE_ONES;
        res.ev         = EV_NONE;
        res.taken      = 1'b0;
        if (hit)
        begin
            unique case (cmd)
                CMD_READ:
                begin
                    unique case (mode) inside
                        MODE_SIN:
                        begin
                            in_latch_next = pins & ~dir;
                            res.rd = merge_io(in_latch_next, out_latch_reg, dir);
                        end
                        MODE_STIN, MODE_BIDIR:
                        begin
                            res.rd = merge_io(in_latch_reg, out_latch_reg, dir);
                            ibf_next = 1'b0;
                            res.taken = 1'b1;
                        end
                        MODE_SOUT, MODE_STOUT:
                        begin
                            if (dir != BYTE_ONES)
                            begin
                                in_latch_next = pins & ~dir;
                            end
                            res.rd = merge_io(in_latch_next, out_latch_reg, dir);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    out_latch_next = data & dir;
                    if (mode == MODE_SOUT)
                    begin
                        res.ev = EV_SIMPLE;
                    end
                    else if (strobed_out)
                    begin
                        obe_next = 1'b0;
                        res.ev = EV_STROBED;
                    end
                end
                CMD_LOAD:
                begin
                    if ((mode != MODE_SIN) && (mode != MODE_SOUT))
                    begin
                        in_latch_next = data & ~dir;
                        if (strobed_in)
                        begin
                            ibf_next = 1'b1;
                        end
                    end
                end
                CMD_DONE:
                begin
                    if (strobed_out)
                    begin
                        obe_next = 1'b1;
                    end
                end
            endcase
        end
        res.out_latch = out_latch_next;
        res.ibf       = ibf_next;
        res.obe       = obe_next;
        res.irq       = irq_en && ((strobed_out && obe_next) || (strobed_in && ibf_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_latch_reg  <= BYTE_ONES;
            out_latch_reg <= BYTE_ZERO;
            ibf_reg       <= 1'b0;
            obe_reg       <= 1'b1;
        end
        else if (fire)
        begin
            in_latch_reg  <= in_latch_next;
            out_latch_reg <= out_latch_next;
            ibf_reg       <= ibf_next;
            obe_reg       <= obe_next;
        end
    end

    a_read_clears_ibf: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hit && (cmd == CMD_READ) && strobed_in |=> !ibf_reg)
        else $error("strobed read left the input buffer full");

    a_write_masked: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hit && (cmd == CMD_WRITE) |=> ((out_latch_reg & ~$past(dir)) == BYTE_ZERO))
        else $error("output latch holds bits of input direction");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(in_latch_reg) && $stable(out_latch_reg)
                  && $stable(ibf_reg) && $stable(obe_reg))
        else $error("port state changed without a word");

    a_taken_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        res.taken |-> (res.ev == EV_NONE) && !res.ibf)
        else $error("input taken together with an output event");

endmodule

// File: hw/rtl/parallel_port_handshake_core.sv
// Three-port parallel interface with strobed handshaking. Each word on the input channel is a
// bus read, a bus write, a strobed input load or an output-done event for port A, B or C, and
// each produces exactly one word on the output channel with the read byte, all three output
// latches, the handshake flags and interrupt requests. The block takes one word per clock unless
// the result register is stalled: a word is held in an input register, is worked in a single
// pass against the port latches and flags, and lands in the result register, and the next word
// may be accepted in the same cycle as the previous one is worked. A stalled result register
// holds the input register too. Configuration registers are written through cfg_write,
// cfg_index and cfg_data and should only be changed while no word is in flight.
module parallel_port_handshake_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [1:0] port,
    input  logic [7:0] data,
    input  logic [7:0] pins,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [7:0] out_a,
    output logic [7:0] out_b,
    output logic [7:0] out_c,
    output logic [1:0] output_event,
    output logic       input_taken,
    output logic       ibf_a,
    output logic       obe_a,
    output logic       ibf_b,
    output logic       obe_b,
    output logic       irq_a,
    output logic       irq_b
);
    import pph_pkg::*;

    logic [2:0] mode_a_reg;
    logic [2:0] mode_b_reg;
    logic [2:0] mode_c_reg;
    logic [7:0] dir_a_reg;
    logic [7:0] dir_b_reg;
    logic [7:0] dir_c_reg;
    logic [7:0] impl_c_reg;
    logic [1:0] irq_en_reg;

    logic       in_pend_reg;
    cmd_t       cmd_reg;
    logic [1:0] port_reg;
    logic [7:0] data_reg;
    logic [7:0] pins_reg;
    logic       fire;
    logic       in_load;

    port_res_t  res_a;
    port_res_t  res_b;

    logic [7:0] in_c_reg;
    logic [7:0] in_c_next;
    logic [7:0] out_c_reg;
    logic [7:0] out_c_next;
    logic [7:0] rd_c;
    event_t     ev_c;

    logic       out_valid_reg;
    logic [7:0] rd_reg;
    logic [7:0] out_a_reg;
    logic [7:0] out_b_reg;
    logic [7:0] out_c_res_reg;
    event_t     ev_reg;
    logic       taken_reg;
    logic       ibf_a_reg;
    logic       obe_a_reg;
    logic       ibf_b_reg;
    logic       obe_b_reg;
    logic       irq_a_reg;
    logic       irq_b_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_a_reg <= MODE_SIN;
            mode_b_reg <= MODE_SIN;
            mode_c_reg <= MODE_SIN;
            dir_a_reg  <= BYTE_ZERO;
            dir_b_reg  <= BYTE_ZERO;
            dir_c_reg  <= BYTE_ZERO;
            impl_c_reg <= BYTE_ONES;
            irq_en_reg <= 2'b00;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE_A: mode_a_reg <= cfg_data[2:0];
                REG_MODE_B: mode_b_reg <= cfg_data[2:0];
                REG_MODE_C: mode_c_reg <= cfg_data[2:0];
                REG_DIR_A:  dir_a_reg  <= cfg_data;
                REG_DIR_B:  dir_b_reg  <= cfg_data;
                REG_DIR_C:  dir_c_reg  <= cfg_data;
                REG_IMPL_C: impl_c_reg <= cfg_data;
                REG_IRQ_EN: irq_en_reg <= cfg_data[1:0];
            endcase
        end
    end

    // input register
    assign fire     = in_pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_pend_reg && !fire;
    assign in_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pend_reg <= 1'b0;
        end
        else if (in_load || fire)
        begin
            in_pend_reg <= in_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            cmd_reg  <= cmd_t'(cmd);
            port_reg <= port;
            data_reg <= data;
            pins_reg <= pins;
        end
    end

    pph_port u_port_a
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .hit    (port_reg == PORT_A),
        .cmd    (cmd_reg),
        .data   (data_reg),
        .pins   (pins_reg),
        .mode   (mode_a_reg),
        .dir    (dir_a_reg),
        .irq_en (irq_en_reg[0]),
        .res    (res_a)
    );

    pph_port u_port_b
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .hit    (port_reg == PORT_B),
        .cmd    (cmd_reg),
        .data   (data_reg),
        .pins   (pins_reg),
        .mode   (mode_b_reg),
        .dir    (dir_b_reg),
        .irq_en (irq_en_reg[1]),
        .res    (res_b)
    );

    // port c, simple modes only
    always_comb
    begin
        in_c_next  = in_c_reg;
        out_c_next = out_c_reg;
        rd_c       = BYTE_ONES;
        ev_c       = EV_NONE;
        if (port_reg == PORT_C)
        begin
            if (cmd_reg == CMD_READ)
            begin
                if (mode_c_reg == MODE_SIN)
                begin
                    in_c_next = pins_reg & ~dir_c_reg & impl_c_reg;
                    rd_c = in_c_next;
                end
                else if (mode_c_reg == MODE_SOUT)
                begin
                    if (dir_c_reg != BYTE_ONES)
                    begin
                        in_c_next = pins_reg & ~dir_c_reg & impl_c_reg;
                    end
                    rd_c = merge_io(in_c_next, out_c_reg, dir_c_reg);
                end
            end
            else if ((cmd_reg == CMD_WRITE) && (mode_c_reg == MODE_SOUT))
            begin
                out_c_next = data_reg & dir_c_reg & impl_c_reg;
                ev_c = EV_SIMPLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_c_reg  <= BYTE_ONES;
            out_c_reg <= BYTE_ZERO;
        end
        else if (fire)
        begin
            in_c_reg  <= in_c_next;
            out_c_reg <= out_c_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire || !out_stall)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg        <= res_a.rd & res_b.rd & rd_c;
            out_a_reg     <= res_a.out_latch;
            out_b_reg     <= res_b.out_latch;
            out_c_res_reg <= out_c_next;
            ev_reg        <= event_t'(res_a.ev | res_b.ev | ev_c);
            taken_reg     <= res_a.taken | res_b.taken;
            ibf_a_reg     <= res_a.ibf;
            obe_a_reg     <= res_a.obe;
            ibf_b_reg     <= res_b.ibf;
            obe_b_reg     <= res_b.obe;
            irq_a_reg     <= res_a.irq;
            irq_b_reg     <= res_b.irq;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_reg;
    assign out_a        = out_a_reg;
    assign out_b        = out_b_reg;
    assign out_c        = out_c_res_reg;
    assign output_event = ev_reg;
    assign input_taken  = taken_reg;
    assign ibf_a        = ibf_a_reg;
    assign obe_a        = obe_a_reg;
    assign ibf_b        = ibf_b_reg;
    assign obe_b        = obe_b_reg;
    assign irq_a        = irq_a_reg;
    assign irq_b        = irq_b_reg;

    a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("worked word did not reach the result register");

    a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
        in_load |=> in_pend_reg)
        else $error("accepted word lost before the work stage");

    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> $countones({res_a.ev != EV_NONE, res_b.ev != EV_NONE, ev_c != EV_NONE}) <= 1)
        else $error("more than one port raised an output event");

endmodule
